@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the phase sequencer of the serial word sender.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is low.
`define SWSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds, off while reset is low.
`define SWSP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/swsp_pkg.sv @@
package swsp_pkg;

    // Default sizes
    localparam int WORD_WIDTH_DEF  = 32;
    localparam int TIMER_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int IN_WORD_WIDTH   = 32;
    localparam int IN_COUNT_WIDTH  = 6;
    localparam int REG_WIDTH       = 16;
    localparam int CFG_IDX_WIDTH   = 3;

    // Register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_HOLD  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_GAP   = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_PULSE = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BIT_LOW     = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BIT_HIGH    = 3'd4;

    // Register reset values, in microseconds
    localparam logic [REG_WIDTH-1:0] RST_START_HOLD  = 16'd498;
    localparam logic [REG_WIDTH-1:0] RST_START_GAP   = 16'd1007;
    localparam logic [REG_WIDTH-1:0] RST_START_PULSE = 16'd501;
    localparam logic [REG_WIDTH-1:0] RST_BIT_LOW     = 16'd494;
    localparam logic [REG_WIDTH-1:0] RST_BIT_HIGH    = 16'd502;

    // Phase durations handed from the register file to the sequencer
    typedef struct packed {
        logic [REG_WIDTH-1:0] start_hold_us;
        logic [REG_WIDTH-1:0] start_gap_us;
        logic [REG_WIDTH-1:0] start_pulse_us;
        logic [REG_WIDTH-1:0] bit_low_us;
        logic [REG_WIDTH-1:0] bit_high_us;
    } t_cfg;

    // One result transaction
    typedef struct packed {
        logic data_level;
        logic clock_level;
        logic busy_res;
        logic finished;
    } t_result;

endpackage

@@ rtl/core/swsp_cfg_regs.sv @@
module swsp_cfg_regs #(
    parameter int TIMER_WIDTH = swsp_pkg::TIMER_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [swsp_pkg::CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [swsp_pkg::REG_WIDTH-1:0]     i_cfg_data,
    output swsp_pkg::t_cfg                     o_cfg
);

    localparam int TW = (TIMER_WIDTH < swsp_pkg::REG_WIDTH) ? TIMER_WIDTH
                                                            : swsp_pkg::REG_WIDTH;
    localparam logic [swsp_pkg::REG_WIDTH-1:0] MASK =
        swsp_pkg::REG_WIDTH'((33'd1 << TW) - 33'd1);

    swsp_pkg::t_cfg r_cfg;
    logic [swsp_pkg::REG_WIDTH-1:0] wr_value;

    // Keep only the bits the phase timer can count
    assign wr_value = i_cfg_data & MASK;

    // Decode the write index; drop writes beyond the last register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_hold_us  <= swsp_pkg::RST_START_HOLD & MASK;
            r_cfg.start_gap_us   <= swsp_pkg::RST_START_GAP & MASK;
            r_cfg.start_pulse_us <= swsp_pkg::RST_START_PULSE & MASK;
            r_cfg.bit_low_us     <= swsp_pkg::RST_BIT_LOW & MASK;
            r_cfg.bit_high_us    <= swsp_pkg::RST_BIT_HIGH & MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                swsp_pkg::CFG_START_HOLD:  r_cfg.start_hold_us  <= wr_value;
                swsp_pkg::CFG_START_GAP:   r_cfg.start_gap_us   <= wr_value;
                swsp_pkg::CFG_START_PULSE: r_cfg.start_pulse_us <= wr_value;
                swsp_pkg::CFG_BIT_LOW:     r_cfg.bit_low_us     <= wr_value;
                swsp_pkg::CFG_BIT_HIGH:    r_cfg.bit_high_us    <= wr_value;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/swsp_seq.sv @@
`include "assert_macros.svh"

module swsp_seq #(
    parameter int WORD_WIDTH  = swsp_pkg::WORD_WIDTH_DEF,
    parameter int TIMER_WIDTH = swsp_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic                                i_mode,
    input  logic [swsp_pkg::IN_WORD_WIDTH-1:0]  i_data_word,
    input  logic [swsp_pkg::IN_COUNT_WIDTH-1:0] i_bit_count,
    input  swsp_pkg::t_cfg                      i_cfg,
    output swsp_pkg::t_result                   o_result
);

    localparam int TW  = (TIMER_WIDTH < swsp_pkg::REG_WIDTH) ? TIMER_WIDTH
                                                             : swsp_pkg::REG_WIDTH;
    localparam int BLW = $clog2(WORD_WIDTH + 1);
    localparam int IW  = (WORD_WIDTH > 1) ? $clog2(WORD_WIDTH) : 1;
    localparam int CW  = (BLW > swsp_pkg::IN_COUNT_WIDTH) ? BLW : swsp_pkg::IN_COUNT_WIDTH;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_HOLD  = 6'b000010,
        PH_GAP   = 6'b000100,
        PH_PULSE = 6'b001000,
        PH_BLOW  = 6'b010000,
        PH_BHIGH = 6'b100000
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [TW-1:0]         r_ticks, n_ticks;
    logic [WORD_WIDTH-1:0] r_word, n_word;
    logic [BLW-1:0]        r_bits_left, n_bits_left;
    logic                  r_data, n_data;
    logic                  r_clk, n_clk;
    logic                  n_finished;

    logic [WORD_WIDTH-1:0]         load_word;
    logic [BLW-1:0]                load_count;
    logic [swsp_pkg::REG_WIDTH-1:0] len_sel;
    logic [TW-1:0]                 len_eff;
    logic [TW:0]                   tick_inc;
    logic                          phase_end;
    logic [BLW-1:0]                bits_dec;
    logic [BLW-1:0]                idx_now;
    logic [BLW-1:0]                idx_next;
    logic                          end_send;

    // Fit the input word to the shift register
    generate
        if (WORD_WIDTH <= swsp_pkg::IN_WORD_WIDTH) begin : g_word_trunc
            assign load_word = i_data_word[WORD_WIDTH-1:0];
        end else begin : g_word_ext
            assign load_word = {{(WORD_WIDTH - swsp_pkg::IN_WORD_WIDTH){1'b0}}, i_data_word};
        end
    endgenerate

    // Saturate the bit count at the word width
    always_comb begin
        if (CW'(i_bit_count) > CW'(WORD_WIDTH)) begin
            load_count = BLW'(WORD_WIDTH);
        end else begin
            load_count = BLW'(i_bit_count);
        end
    end

    // Select the length of the running phase; zero counts as one tick
    always_comb begin
        unique case (r_phase)
            PH_HOLD:  len_sel = i_cfg.start_hold_us;
            PH_GAP:   len_sel = i_cfg.start_gap_us;
            PH_PULSE: len_sel = i_cfg.start_pulse_us;
            PH_BLOW:  len_sel = i_cfg.bit_low_us;
            default:  len_sel = i_cfg.bit_high_us;
        endcase
    end

    assign len_eff   = (len_sel[TW-1:0] == '0) ? TW'(1) : len_sel[TW-1:0];
    assign tick_inc  = {1'b0, r_ticks} + (TW + 1)'(1);
    assign phase_end = !(tick_inc < {1'b0, len_eff});
    assign bits_dec  = (r_bits_left != '0) ? r_bits_left - BLW'(1) : '0;
    assign idx_now   = r_bits_left - BLW'(1);
    assign idx_next  = bits_dec - BLW'(1);

    // Work out the state and line levels after this transaction
    always_comb begin
        n_phase     = r_phase;
        n_ticks     = r_ticks;
        n_word      = r_word;
        n_bits_left = r_bits_left;
        n_data      = r_data;
        n_clk       = r_clk;
        n_finished  = 1'b0;
        end_send    = 1'b0;
        if (i_step) begin
            if (i_mode) begin
                // Start a send unless the load is empty or a send is running
                if (load_word != '0 && load_count != '0 && r_phase == PH_IDLE) begin
                    n_word      = load_word;
                    n_bits_left = load_count;
                    n_phase     = PH_HOLD;
                    n_ticks     = '0;
                    n_data      = 1'b0;
                    n_clk       = 1'b1;
                end
            end else if (r_phase != PH_IDLE) begin
                if (!phase_end) begin
                    n_ticks = tick_inc[TW-1:0];
                end else begin
                    n_ticks = '0;
                    unique case (r_phase)
                        PH_HOLD: begin
                            n_data  = 1'b1;
                            n_clk   = 1'b0;
                            n_phase = PH_GAP;
                        end
                        PH_GAP: begin
                            n_clk   = 1'b1;
                            n_phase = PH_PULSE;
                        end
                        PH_PULSE: begin
                            n_clk = 1'b0;
                            if (r_bits_left != '0) begin
                                n_data  = r_word[idx_now[IW-1:0]];
                                n_phase = PH_BLOW;
                            end else begin
                                end_send = 1'b1;
                            end
                        end
                        PH_BLOW: begin
                            n_clk   = 1'b1;
                            n_phase = PH_BHIGH;
                        end
                        PH_BHIGH: begin
                            n_clk       = 1'b0;
                            n_bits_left = bits_dec;
                            if (bits_dec != '0) begin
                                n_data  = r_word[idx_next[IW-1:0]];
                                n_phase = PH_BLOW;
                            end else begin
                                end_send = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    // Drop both lines and go idle after the last bit
                    if (end_send) begin
                        n_data      = 1'b0;
                        n_clk       = 1'b0;
                        n_phase     = PH_IDLE;
                        n_bits_left = '0;
                        n_finished  = 1'b1;
                    end
                end
            end
        end
    end

    // Hold the send state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ticks     <= '0;
            r_word      <= '0;
            r_bits_left <= '0;
            r_data      <= 1'b0;
            r_clk       <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_ticks     <= n_ticks;
            r_word      <= n_word;
            r_bits_left <= n_bits_left;
            r_data      <= n_data;
            r_clk       <= n_clk;
        end
    end

    assign o_result.data_level  = n_data;
    assign o_result.clock_level = n_clk;
    assign o_result.busy_res    = (n_phase != PH_IDLE);
    assign o_result.finished    = n_finished;

    `SWSP_ASSERT(a_idle_lines_low, i_clk, i_rst_n, r_phase == PH_IDLE |-> !r_data && !r_clk, "lines not low while idle")
    `SWSP_ASSERT_NEVER(a_busy_without_bits, i_clk, i_rst_n, r_phase != PH_IDLE && r_bits_left == '0, "send running with no bits left")
    `SWSP_ASSERT(a_idle_ticks_clear, i_clk, i_rst_n, r_phase == PH_IDLE |-> r_ticks == '0, "tick count left over while idle")
    `SWSP_ASSERT(a_finish_from_end, i_clk, i_rst_n, n_finished |-> r_phase == PH_BHIGH || r_phase == PH_PULSE, "send ended from a wrong phase")

endmodule

@@ rtl/core/serial_word_sender_with_preamble.sv @@
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_mode, i_data_word, i_bit_count
// result    o_out_valid / i_out_ready  o_data_level, o_clock_level, o_busy_res, o_finished
// config    i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// Each transaction passes through the input register, then through the phase
// sequencer into the result register.
// One transaction is accepted per cycle; the sequencer state advances once each.
// Reset is synchronous, active low; registers return to their reset durations.
// A stalled result holds the pipeline; the input register still takes a
// transaction while empty, and takes the next one as the result register drains.
module serial_word_sender_with_preamble #(
    parameter int WORD_WIDTH  = swsp_pkg::WORD_WIDTH_DEF,
    parameter int TIMER_WIDTH = swsp_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [swsp_pkg::IN_WORD_WIDTH-1:0]  i_data_word,
    input  logic [swsp_pkg::IN_COUNT_WIDTH-1:0] i_bit_count,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_data_level,
    output logic                                o_clock_level,
    output logic                                o_busy_res,
    output logic                                o_finished,
    input  logic                                i_cfg_we,
    input  logic [swsp_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [swsp_pkg::REG_WIDTH-1:0]      i_cfg_data
);

    logic                                r_in_valid;
    logic                                r_in_mode;
    logic [swsp_pkg::IN_WORD_WIDTH-1:0]  r_in_word;
    logic [swsp_pkg::IN_COUNT_WIDTH-1:0] r_in_count;
    logic                                r_out_valid;
    swsp_pkg::t_result                   r_out;

    swsp_pkg::t_cfg    cfg;
    swsp_pkg::t_result seq_result;
    logic              out_take;
    logic              s1_fire;
    logic              in_fire;

    assign out_take   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_in_valid && out_take;
    assign o_in_ready = !r_in_valid || out_take;
    assign in_fire    = i_in_valid && o_in_ready;

    swsp_cfg_regs #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    swsp_seq #(
        .WORD_WIDTH  (WORD_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_fire),
        .i_mode      (r_in_mode),
        .i_data_word (r_in_word),
        .i_bit_count (r_in_count),
        .i_cfg       (cfg),
        .o_result    (seq_result)
    );

    // Advance the valid flags of the input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (s1_fire) begin
                r_in_valid <= 1'b0;
            end
            if (out_take) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Capture the input transaction and the finished result
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_mode  <= i_mode;
            r_in_word  <= i_data_word;
            r_in_count <= i_bit_count;
        end
        if (s1_fire) begin
            r_out <= seq_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_level  = r_out.data_level;
    assign o_clock_level = r_out.clock_level;
    assign o_busy_res    = r_out.busy_res;
    assign o_finished    = r_out.finished;

endmodule

@@ tb/sv/serial_word_sender_with_preamble_checker.sv @@
module serial_word_sender_with_preamble_checker
    import swsp_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic                      i_mode,
    input  logic [IN_WORD_WIDTH-1:0]  i_data_word,
    input  logic [IN_COUNT_WIDTH-1:0] i_bit_count,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic                      i_data_level,
    input  logic                      i_clock_level,
    input  logic                      i_busy_res,
    input  logic                      i_finished,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  logic [REG_WIDTH-1:0]      i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_sends_done
);

    typedef enum logic [2:0] {
        LINE_IDLE,
        LINE_HOLD,
        LINE_GAP,
        LINE_PULSE,
        LINE_BIT_LOW,
        LINE_BIT_HIGH
    } t_line_phase;

    localparam int MAX_REPORTS = 20;

    // Mirror of the sender: durations, sequencer and line levels
    t_cfg                     durations;
    t_line_phase              line_phase;
    logic [REG_WIDTH-1:0]     tick_count;
    logic [IN_WORD_WIDTH-1:0] word_left;
    logic [IN_COUNT_WIDTH-1:0] bits_left;
    logic                     data_line;
    logic                     clock_line;

    t_result expected_levels[$];
    t_result next_levels;
    t_result want_levels;
    t_result got_levels;
    int      fail_count;
    int      checked;
    int      sends_done;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_sends_done = 0;
    end

    // Length of the current phase; a zero duration still takes one tick
    function logic [REG_WIDTH:0] current_length();
        logic [REG_WIDTH-1:0] len;
        case (line_phase)
            LINE_HOLD:    len = durations.start_hold_us;
            LINE_GAP:     len = durations.start_gap_us;
            LINE_PULSE:   len = durations.start_pulse_us;
            LINE_BIT_LOW: len = durations.bit_low_us;
            default:      len = durations.bit_high_us;
        endcase
        current_length = (len == '0) ? 17'd1 : {1'b0, len};
    endfunction

    // Put the next bit on the data line with the clock low
    task start_bit();
        data_line  = word_left[bits_left - 6'd1];
        clock_line = 1'b0;
        line_phase = LINE_BIT_LOW;
    endtask

    // Count one microsecond; move to the next phase on its last tick
    task advance_line(output logic ended);
        logic [REG_WIDTH:0] len;
        len   = current_length();
        ended = 1'b0;
        if ({1'b0, tick_count} + 17'd1 < len) begin
            tick_count = tick_count + 16'd1;
        end else begin
            tick_count = '0;
            case (line_phase)
                LINE_HOLD: begin
                    data_line  = 1'b1;
                    clock_line = 1'b0;
                    line_phase = LINE_GAP;
                end
                LINE_GAP: begin
                    clock_line = 1'b1;
                    line_phase = LINE_PULSE;
                end
                LINE_PULSE: begin
                    clock_line = 1'b0;
                    if (bits_left != '0) start_bit();
                    else ended = 1'b1;
                end
                LINE_BIT_LOW: begin
                    clock_line = 1'b1;
                    line_phase = LINE_BIT_HIGH;
                end
                default: begin
                    clock_line = 1'b0;
                    if (bits_left != '0) bits_left = bits_left - 6'd1;
                    if (bits_left != '0) start_bit();
                    else ended = 1'b1;
                end
            endcase
            // Drop both lines once the last bit is out
            if (ended) begin
                data_line  = 1'b0;
                clock_line = 1'b0;
                line_phase = LINE_IDLE;
                bits_left  = '0;
            end
        end
    endtask

    // Work out the levels that one transaction leaves on the lines
    task predict_levels(input logic m, input logic [IN_WORD_WIDTH-1:0] w,
                        input logic [IN_COUNT_WIDTH-1:0] n, output t_result res);
        logic                      ended;
        logic [IN_COUNT_WIDTH-1:0] count;
        ended = 1'b0;
        // The word register is as wide as the input word, so only the count saturates
        count = (n > WORD_WIDTH_DEF) ? WORD_WIDTH_DEF[IN_COUNT_WIDTH-1:0] : n;
        if (m) begin
            if (w != '0 && count != '0 && line_phase == LINE_IDLE) begin
                word_left  = w;
                bits_left  = count;
                line_phase = LINE_HOLD;
                tick_count = '0;
                data_line  = 1'b0;
                clock_line = 1'b1;
            end
        end else if (line_phase != LINE_IDLE) begin
            advance_line(ended);
        end
        res.data_level  = data_line;
        res.clock_level = clock_line;
        res.busy_res    = (line_phase != LINE_IDLE);
        res.finished    = ended;
    endtask

    // Compare one result transaction with the oldest prediction
    task check_result();
        got_levels.data_level  = i_data_level;
        got_levels.clock_level = i_clock_level;
        got_levels.busy_res    = i_busy_res;
        got_levels.finished    = i_finished;
        checked++;
        if (expected_levels.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: result with nothing expected: data=%b clock=%b busy=%b done=%b",
                         $time, got_levels.data_level, got_levels.clock_level,
                         got_levels.busy_res, got_levels.finished);
        end else begin
            want_levels = expected_levels.pop_front();
            if (want_levels.finished) sends_done++;
            if (want_levels != got_levels) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result %0d expected data=%b clock=%b busy=%b done=%b, got data=%b clock=%b busy=%b done=%b",
                             $time, checked,
                             want_levels.data_level, want_levels.clock_level,
                             want_levels.busy_res, want_levels.finished,
                             got_levels.data_level, got_levels.clock_level,
                             got_levels.busy_res, got_levels.finished);
            end
        end
    endtask

    // Track configuration, check results, then queue predictions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            durations  <= {RST_START_HOLD, RST_START_GAP, RST_START_PULSE,
                           RST_BIT_LOW, RST_BIT_HIGH};
            line_phase <= LINE_IDLE;
            tick_count <= '0;
            word_left  <= '0;
            bits_left  <= '0;
            data_line  <= 1'b0;
            clock_line <= 1'b0;
            expected_levels.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_HOLD:  durations.start_hold_us  = i_cfg_data;
                    CFG_START_GAP:   durations.start_gap_us   = i_cfg_data;
                    CFG_START_PULSE: durations.start_pulse_us = i_cfg_data;
                    CFG_BIT_LOW:     durations.bit_low_us     = i_cfg_data;
                    CFG_BIT_HIGH:    durations.bit_high_us    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) check_result();
            if (i_in_valid && i_in_ready) begin
                predict_levels(i_mode, i_data_word, i_bit_count, next_levels);
                expected_levels.push_back(next_levels);
            end
        end
        o_pending    <= expected_levels.size();
        o_fail_count <= fail_count;
        o_checked    <= checked;
        o_sends_done <= sends_done;
    end

    initial begin
        fail_count = 0;
        checked    = 0;
        sends_done = 0;
    end

endmodule

@@ tb/sv/serial_word_sender_with_preamble_tb.sv @@
module serial_word_sender_with_preamble_tb;
    import swsp_pkg::*;

    localparam int CYCLE_LIMIT      = 200_000;
    localparam int RANDOM_WORK      = 1500;
    localparam int DRAIN_CYCLES     = 8;
    localparam int FULL_SCALE_TICKS = 64;

    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    localparam logic [REG_WIDTH-1:0] DURATION_MAX = 16'hFFFF;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      mode;
    logic [IN_WORD_WIDTH-1:0]  data_word;
    logic [IN_COUNT_WIDTH-1:0] bit_count;
    logic                      out_valid;
    logic                      out_ready;
    logic                      data_level;
    logic                      clock_level;
    logic                      busy_res;
    logic                      finished;
    logic                      cfg_we;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index;
    logic [REG_WIDTH-1:0]      cfg_data;

    int fail_count;
    int pending;
    int checked;
    int sends_done;

    // Durations as last written, used to size tick runs and the work budget
    t_cfg durations_now;

    int items_sent;
    int cycle_count;
    int burst_left;
    int gap_max;
    int stall_style;
    int stall_period;
    int stall_hold;
    int stall_tick;
    int random_work;
    int phase_work;
    int settings_used;

    always #4 clk = ~clk;

    serial_word_sender_with_preamble i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_mode        (mode),
        .i_data_word   (data_word),
        .i_bit_count   (bit_count),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_data_level  (data_level),
        .o_clock_level (clock_level),
        .o_busy_res    (busy_res),
        .o_finished    (finished),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    serial_word_sender_with_preamble_checker u_levels_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_mode        (mode),
        .i_data_word   (data_word),
        .i_bit_count   (bit_count),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_data_level  (data_level),
        .i_clock_level (clock_level),
        .i_busy_res    (busy_res),
        .i_finished    (finished),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_sends_done  (sends_done)
    );

    // Stall the result channel on the pattern chosen for the current phase
    always @(negedge clk) begin
        stall_tick <= stall_tick + 1;
        case (stall_style)
            STALL_NONE:  out_ready <= 1'b1;
            STALL_LIGHT: out_ready <= ($urandom_range(3, 0) != 0);
            STALL_HEAVY: out_ready <= ($urandom_range(3, 0) == 0);
            default:     out_ready <= ((stall_tick % stall_period) >= stall_hold);
        endcase
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: no progress after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int phase_span(input logic [REG_WIDTH-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    // Ticks from load to the end of a send under the current durations
    function automatic int send_span(input logic [IN_COUNT_WIDTH-1:0] n);
        int bits;
        bits = (n > WORD_WIDTH_DEF) ? WORD_WIDTH_DEF : int'(n);
        return phase_span(durations_now.start_hold_us)
             + phase_span(durations_now.start_gap_us)
             + phase_span(durations_now.start_pulse_us)
             + bits * (phase_span(durations_now.bit_low_us)
                       + phase_span(durations_now.bit_high_us));
    endfunction

    function automatic logic [REG_WIDTH-1:0] pick_duration();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60) return REG_WIDTH'($urandom_range(3, 0));
        else if (r < 92) return REG_WIDTH'($urandom_range(12, 4));
        else return REG_WIDTH'($urandom_range(40, 13));
    endfunction

    function automatic logic [IN_WORD_WIDTH-1:0] pick_word();
        logic [IN_WORD_WIDTH-1:0] w;
        case ($urandom_range(3, 0))
            0:       w = $urandom;
            1:       w = 32'h1 << $urandom_range(31, 0);
            2:       w = $urandom_range(255, 1);
            default: w = ~(32'h1 << $urandom_range(31, 0));
        endcase
        return (w == '0) ? 32'h1 : w;
    endfunction

    // Offer one transaction and hold it until accepted; idle between bursts
    task automatic push_item(input logic m, input logic [IN_WORD_WIDTH-1:0] w,
                             input logic [IN_COUNT_WIDTH-1:0] n);
        in_valid  <= 1'b1;
        mode      <= m;
        data_word <= w;
        bit_count <= n;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (gap_max != 0) begin
            if (burst_left == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(gap_max, 1)) @(negedge clk);
                burst_left = $urandom_range(24, 1);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Issue ticks, now and then a stray load among them
    task automatic tick_run(input int count, input int stray_per_mille);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(999, 0) < stray_per_mille)
                push_item(MODE_LOAD, $urandom, IN_COUNT_WIDTH'($urandom_range(63, 0)));
            push_item(MODE_TICK, $urandom, IN_COUNT_WIDTH'($urandom_range(63, 0)));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [REG_WIDTH-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_START_HOLD:  durations_now.start_hold_us  = val;
            CFG_START_GAP:   durations_now.start_gap_us   = val;
            CFG_START_PULSE: durations_now.start_pulse_us = val;
            CFG_BIT_LOW:     durations_now.bit_low_us     = val;
            CFG_BIT_HIGH:    durations_now.bit_high_us    = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic close_writes();
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    task automatic write_all(input logic [REG_WIDTH-1:0] hold,
                             input logic [REG_WIDTH-1:0] gap,
                             input logic [REG_WIDTH-1:0] pulse,
                             input logic [REG_WIDTH-1:0] low,
                             input logic [REG_WIDTH-1:0] high);
        write_reg(CFG_START_HOLD, hold);
        write_reg(CFG_START_GAP, gap);
        write_reg(CFG_START_PULSE, pulse);
        write_reg(CFG_BIT_LOW, low);
        write_reg(CFG_BIT_HIGH, high);
        close_writes();
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain();
        if (in_valid) in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // Rewrite some durations, and sometimes poke an unused index
    task automatic shuffle_durations();
        int idx;
        for (idx = CFG_START_HOLD; idx <= CFG_BIT_HIGH; idx++)
            if ($urandom_range(3, 0) != 0) write_reg(idx[CFG_IDX_WIDTH-1:0], pick_duration());
        if ($urandom_range(3, 0) == 0)
            write_reg(CFG_IDX_WIDTH'($urandom_range(7, CFG_BIT_HIGH + 1)),
                      REG_WIDTH'($urandom));
        close_writes();
    endtask

    // A full send: load, then about as many ticks as it needs
    task automatic send_sequence();
        logic [IN_WORD_WIDTH-1:0]  w;
        logic [IN_COUNT_WIDTH-1:0] n;
        int                        span;
        int                        r;
        w = pick_word();
        r = $urandom_range(99, 0);
        if (r < 80) n = IN_COUNT_WIDTH'($urandom_range(8, 1));
        else if (r < 95) n = IN_COUNT_WIDTH'($urandom_range(32, 9));
        else n = IN_COUNT_WIDTH'($urandom_range(63, 33));
        span = send_span(n);
        random_work += span + 1;
        phase_work  += span + 1;
        push_item(MODE_LOAD, w, n);
        // Cut some sends short so the next load lands while busy; overrun others
        r = $urandom_range(99, 0);
        if (r < 15) span = (span > 5) ? span - $urandom_range(5, 1) : 0;
        else if (r < 30) span += $urandom_range(6, 1);
        tick_run(span, 40);
    endtask

    // A load that must be ignored, followed by a few ticks
    task automatic broken_sequence();
        if ($urandom_range(1, 0) == 0)
            push_item(MODE_LOAD, '0, IN_COUNT_WIDTH'($urandom_range(63, 0)));
        else
            push_item(MODE_LOAD, $urandom, '0);
        tick_run($urandom_range(4, 0), 0);
    endtask

    initial begin
        logic [IN_WORD_WIDTH-1:0] word_pick;
        int                       phase_target;
        int                       r;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = MODE_TICK;
        data_word     = '0;
        bit_count     = '0;
        out_ready     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_START_HOLD;
        cfg_data      = '0;
        durations_now = {RST_START_HOLD, RST_START_GAP, RST_START_PULSE,
                         RST_BIT_LOW, RST_BIT_HIGH};
        items_sent    = 0;
        cycle_count   = 0;
        burst_left    = 4;
        gap_max       = 2;
        stall_style   = STALL_LIGHT;
        stall_period  = 8;
        stall_hold    = 3;
        stall_tick    = 0;
        random_work   = 0;
        phase_work    = 0;
        settings_used = 1;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // One-bit send at the reset durations, run just past the first preamble phase
        word_pick = pick_word();
        push_item(MODE_LOAD, word_pick, 6'd1);
        tick_run(int'(RST_START_HOLD) + 2, 0);
        drain();

        // Directed: short durations, zero standing for one tick; finish the open send
        write_all(16'd0, 16'd1, 16'd1, 16'd0, 16'd2);
        tick_run(send_span(6'd1), 0);
        push_item(MODE_TICK, 32'hFFFF_FFFF, 6'd63);
        push_item(MODE_LOAD, 32'h0000_0000, 6'd63);
        push_item(MODE_LOAD, 32'hFFFF_FFFF, 6'd0);
        push_item(MODE_LOAD, 32'h0000_0002, 6'd2);
        push_item(MODE_LOAD, 32'h0000_0001, 6'd1);
        tick_run(send_span(6'd2), 0);
        push_item(MODE_TICK, 32'h0000_0000, 6'd0);
        // Count above the word width: all 32 bits go out
        push_item(MODE_LOAD, 32'h8000_0001, 6'd63);

        // Random phases, each under fresh durations and a fresh idle and stall pattern
        while (random_work < RANDOM_WORK) begin
            drain();
            shuffle_durations();
            case ($urandom_range(2, 0))
                0:       gap_max = 0;
                1:       gap_max = 2;
                default: gap_max = 6;
            endcase
            stall_period = $urandom_range(16, 4);
            stall_hold   = $urandom_range(stall_period - 1, 1);
            stall_style  = $urandom_range(STALL_PERIODIC, STALL_NONE);
            phase_work   = 0;
            phase_target = $urandom_range(350, 150);
            while (phase_work < phase_target) begin
                r = $urandom_range(15, 0);
                if (r == 0) begin
                    repeat ($urandom_range(3, 1))
                        push_item(1'($urandom_range(1, 0)), $urandom,
                                  IN_COUNT_WIDTH'($urandom_range(63, 0)));
                end else if (r == 1) begin
                    broken_sequence();
                end else begin
                    send_sequence();
                end
            end
        end

        // Longest durations on every register, streamed without idling
        drain();
        write_all(DURATION_MAX, DURATION_MAX, DURATION_MAX, DURATION_MAX, DURATION_MAX);
        gap_max     = 0;
        stall_style = STALL_NONE;
        word_pick   = pick_word();
        push_item(MODE_LOAD, word_pick, 6'd1);
        tick_run(FULL_SCALE_TICKS, 1);
        push_item(MODE_TICK, '0, '0);

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d transactions under %0d duration settings,",
                 items_sent, settings_used);
        $display("zero and full-scale included; checked %0d results, %0d sends completed.",
                 checked, sends_done);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
